// ----- design/lmc_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lmc_pkg: shared types, codes and glyph tables
// Action codes, controller states, the controller-to-datapath command
// bundle and the 5x7 glyph font used by the LED matrix clock renderer.
// ----------------------------------------------------------------------------
package lmc_pkg;

  // Register indexes on the configuration port.
  localparam logic CFG_DARK_THRESHOLD = 1'b0;
  localparam logic CFG_DIM_TIME       = 1'b1;

  localparam logic [11:0] DARK_THRESHOLD_RST = 12'd2800;
  localparam logic [9:0]  DIM_TIME_RST       = 10'd330;

  // Input action codes.
  typedef enum logic [1:0] {
    ACT_TIME = 2'd0,
    ACT_TEMP = 2'd1,
    ACT_SCAN = 2'd2,
    ACT_NONE = 2'd3
  } action_t;

  typedef enum logic {
    ST_IDLE,
    ST_RENDER
  } state_t;

  // Glyph codes: digits are their own value.
  localparam logic [3:0] GL_COLON  = 4'd10;
  localparam logic [3:0] GL_DEGREE = 4'd11;
  localparam logic [3:0] GL_MINUS  = 4'd12;
  localparam logic [3:0] GL_BLANK  = 4'd13;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic       capture;    // latch glyph codes of a render beat
    logic       scan;       // put out the current row and advance
    logic       wr_en;      // write one composed frame row
    logic [2:0] wr_row;     // frame row written
    logic [2:0] glyph_row;  // glyph row composed
  } dp_cmd_t;

  // Whole glyph, rows packed with row 0 in the low five bits.
  function automatic logic [34:0] glyph_bits(input logic [3:0] code);
    logic [34:0] g;
    case (code)
      4'd0:      g = {5'h06, 5'h09, 5'h09, 5'h09, 5'h09, 5'h09, 5'h06};
      4'd1:      g = {5'h0E, 5'h04, 5'h04, 5'h04, 5'h04, 5'h06, 5'h04};
      4'd2:      g = {5'h0F, 5'h01, 5'h02, 5'h04, 5'h08, 5'h09, 5'h06};
      4'd3:      g = {5'h06, 5'h09, 5'h08, 5'h06, 5'h08, 5'h09, 5'h06};
      4'd4:      g = {5'h08, 5'h08, 5'h0F, 5'h09, 5'h0A, 5'h0C, 5'h08};
      4'd5:      g = {5'h06, 5'h09, 5'h08, 5'h08, 5'h07, 5'h01, 5'h0F};
      4'd6:      g = {5'h06, 5'h09, 5'h09, 5'h07, 5'h01, 5'h02, 5'h04};
      4'd7:      g = {5'h04, 5'h04, 5'h04, 5'h04, 5'h04, 5'h09, 5'h0F};
      4'd8:      g = {5'h06, 5'h09, 5'h09, 5'h06, 5'h09, 5'h09, 5'h06};
      4'd9:      g = {5'h02, 5'h04, 5'h08, 5'h0E, 5'h09, 5'h09, 5'h06};
      GL_COLON:  g = {5'h00, 5'h03, 5'h03, 5'h00, 5'h03, 5'h03, 5'h00};
      GL_DEGREE: g = {5'h0C, 5'h12, 5'h02, 5'h02, 5'h12, 5'h0C, 5'h01};
      GL_MINUS:  g = {5'h00, 5'h00, 5'h00, 5'h03, 5'h00, 5'h00, 5'h00};
      default:   g = '0;
    endcase
    return g;
  endfunction

  // One five-bit row of a glyph.
  function automatic logic [4:0] glyph_row(input logic [3:0] code, input logic [2:0] r);
    logic [34:0] g;
    g = glyph_bits(code);
    return g[5*r +: 5];
  endfunction

  // Tens and ones of a value up to 99, by reciprocal multiply.
  function automatic logic [7:0] split_digits(input logic [6:0] v);
    logic [14:0] p;
    logic [3:0]  tens;
    logic [6:0]  tens_x10;
    logic [6:0]  ones;
    p        = 15'(v) * 15'd205;
    tens     = p[14:11];
    tens_x10 = 7'({tens, 3'b000}) + 7'({tens, 1'b0});
    ones     = v - tens_x10;
    return {tens, ones[3:0]};
  endfunction

endpackage
`default_nettype wire

// ----- design/lmc_in_if.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lmc_in_if: input item channel
// Valid/ready channel carrying one action beat with its operands.
// ----------------------------------------------------------------------------
interface lmc_in_if;
  logic              valid;
  logic              ready;
  logic [1:0]        action;
  logic [5:0]        hour;
  logic [5:0]        minute;
  logic signed [7:0] temperature;
  logic [11:0]       light;

  modport source (output valid, action, hour, minute, temperature, light, input ready);
  modport sink   (input valid, action, hour, minute, temperature, light, output ready);
endinterface
`default_nettype wire

// ----- design/lmc_out_if.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lmc_out_if: scan result channel
// Valid/ready channel carrying one scanned row per beat.
// ----------------------------------------------------------------------------
interface lmc_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] column_bits;
  logic [2:0]  row_address;
  logic [9:0]  on_time;

  modport source (output valid, column_bits, row_address, on_time, input ready);
  modport sink   (input valid, column_bits, row_address, on_time, output ready);
endinterface
`default_nettype wire

// ----- design/led_matrix_clock_render_and_scan.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// led_matrix_clock_render_and_scan: LED matrix clock renderer and row scanner
// Draws time or temperature into an 8x32 frame and scans it out by rows.
// ----------------------------------------------------------------------------
// A render beat (time or temperature) is accepted and its glyph codes
// latched in the same cycle; the sequencer then writes frame rows 1 to 7,
// one per cycle, and only then takes the next beat. A scan beat loads the
// output register; outside a render it is accepted whenever that register
// is empty or being read in the same cycle. Action code 3 is accepted and
// has no effect. Configuration writes take effect at once.
module led_matrix_clock_render_and_scan (
  input  wire logic   clk,
  input  wire logic   rst_n,
  lmc_in_if.sink      in_ch,
  lmc_out_if.source   out_ch,
  input  wire logic   cfg_we,
  input  wire logic   cfg_index,
  input  wire logic [11:0] cfg_data
);
  import lmc_pkg::*;

  dp_cmd_t cmd;

  lmc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_action (in_ch.action),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .cmd       (cmd)
  );

  lmc_datapath u_datapath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .in_action       (in_ch.action),
    .in_hour         (in_ch.hour),
    .in_minute       (in_ch.minute),
    .in_temperature  (in_ch.temperature),
    .in_light        (in_ch.light),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .out_column_bits (out_ch.column_bits),
    .out_row_address (out_ch.row_address),
    .out_on_time     (out_ch.on_time)
  );

endmodule
`default_nettype wire

// ----- design/lmc_ctrl.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lmc_ctrl: handshake and render sequencer
// Accepts beats, steps through the seven glyph rows of a render and keeps
// the occupancy of the output register.
// ----------------------------------------------------------------------------
module lmc_ctrl (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  input  wire logic [1:0]       in_action,
  output logic                  in_ready,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output lmc_pkg::dp_cmd_t      cmd
);
  import lmc_pkg::*;

  state_t     state_r, state_nxt;
  logic [2:0] cnt_r, cnt_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       accept;
  logic       last_row;

  assign accept   = in_valid && in_ready;
  assign last_row = (cnt_r == 3'd6);

  // Next state and row counter.
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    case (state_r)
      ST_IDLE: begin
        cnt_nxt = '0;
        if (accept && ((in_action == ACT_TIME) || (in_action == ACT_TEMP))) begin
          state_nxt = ST_RENDER;
        end
      end
      ST_RENDER: begin
        cnt_nxt = cnt_r + 3'd1;
        if (last_row) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Outputs: handshake and datapath commands.
  always_comb begin
    in_ready      = 1'b0;
    cmd           = '0;
    cmd.wr_row    = cnt_r + 3'd1;
    cmd.glyph_row = cnt_r;
    case (state_r)
      ST_IDLE: begin
        in_ready    = !out_valid_r || out_ready;
        cmd.capture = accept && ((in_action == ACT_TIME) || (in_action == ACT_TEMP));
        cmd.scan    = accept && (in_action == ACT_SCAN);
      end
      ST_RENDER: begin
        cmd.wr_en = 1'b1;
      end
      default: ;
    endcase
  end

  // Output register occupancy.
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (cmd.scan) begin
      out_valid_nxt = 1'b1;
    end
  end

  assign out_valid = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule
`default_nettype wire

// ----- design/lmc_datapath.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lmc_datapath: frame store, glyph composer and row scanner
// Holds the frame, the scan position, the dimming state and the
// configuration registers, and builds one frame row per render cycle.
// ----------------------------------------------------------------------------
module lmc_datapath (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire lmc_pkg::dp_cmd_t  cmd,
  input  wire logic [1:0]        in_action,
  input  wire logic [5:0]        in_hour,
  input  wire logic [5:0]        in_minute,
  input  wire logic signed [7:0] in_temperature,
  input  wire logic [11:0]       in_light,
  input  wire logic              cfg_we,
  input  wire logic              cfg_index,
  input  wire logic [11:0]       cfg_data,
  output logic [31:0]            out_column_bits,
  output logic [2:0]             out_row_address,
  output logic [9:0]             out_on_time
);
  import lmc_pkg::*;

  logic [31:0] frame_r [8];
  logic [3:0]  code_r [5];
  logic [3:0]  code_nxt [5];
  logic        temp_mode_r;
  logic [2:0]  scan_row_r;
  logic [9:0]  dim_on_time_r, dim_on_time_nxt;
  logic [11:0] thr_r;
  logic [9:0]  dim_time_r;
  logic [31:0] col_r;
  logic [2:0]  row_addr_r;

  logic [5:0]  hour_c, minute_c;
  logic [7:0]  hour_d, minute_d, mag_d;
  logic        neg;
  logic [8:0]  mag_full;
  logic [6:0]  mag;
  logic [31:0] row_bits;
  logic [4:0]  g [5];

  // Glyph codes of a render beat.
  always_comb begin
    hour_c   = (in_hour > 6'd23) ? 6'd23 : in_hour;
    minute_c = (in_minute > 6'd59) ? 6'd59 : in_minute;
    hour_d   = split_digits({1'b0, hour_c});
    minute_d = split_digits({1'b0, minute_c});
    neg      = in_temperature[7];
    mag_full = neg ? (9'd0 - {in_temperature[7], in_temperature}) : {1'b0, in_temperature};
    mag      = (mag_full > 9'd99) ? 7'd99 : mag_full[6:0];
    mag_d    = split_digits(mag);
    if (in_action == ACT_TEMP) begin
      code_nxt[0] = neg ? GL_MINUS : GL_BLANK;
      code_nxt[1] = (mag >= 7'd10) ? mag_d[7:4] : GL_BLANK;
      code_nxt[2] = mag_d[3:0];
      code_nxt[3] = GL_DEGREE;
      code_nxt[4] = GL_BLANK;
    end else begin
      code_nxt[0] = hour_d[7:4];
      code_nxt[1] = hour_d[3:0];
      code_nxt[2] = GL_COLON;
      code_nxt[3] = minute_d[7:4];
      code_nxt[4] = minute_d[3:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      for (int i = 0; i < 5; i++) begin
        code_r[i] <= code_nxt[i];
      end
      temp_mode_r <= (in_action == ACT_TEMP);
    end
  end

  // Compose one frame row from the five glyph slots.
  always_comb begin
    for (int i = 0; i < 5; i++) begin
      g[i] = glyph_row(code_r[i], cmd.glyph_row);
    end
    if (temp_mode_r) begin
      row_bits = (32'(g[0]) << 2) | (32'(g[1]) << 6) | (32'(g[2]) << 11) |
                 (32'(g[3]) << 16) | (32'(g[4]) << 20);
    end else begin
      row_bits = (32'(g[0]) << 2) | (32'(g[1]) << 7) | (32'(g[2]) << 12) |
                 (32'(g[3]) << 15) | (32'(g[4]) << 20);
    end
  end

  // Frame store; row 0 is never written.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int r = 0; r < 8; r++) begin
        frame_r[r] <= '0;
      end
    end else if (cmd.wr_en) begin
      frame_r[cmd.wr_row] <= row_bits;
    end
  end

  // Dimming is chosen on every row-0 scan.
  always_comb begin
    dim_on_time_nxt = dim_on_time_r;
    if (cmd.scan && (scan_row_r == 3'd0)) begin
      dim_on_time_nxt = (in_light > thr_r) ? dim_time_r : 10'd0;
    end
  end

  // Scan position, dimming state and configuration.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scan_row_r    <= '0;
      dim_on_time_r <= '0;
      thr_r         <= DARK_THRESHOLD_RST;
      dim_time_r    <= DIM_TIME_RST;
    end else begin
      dim_on_time_r <= dim_on_time_nxt;
      if (cmd.scan) begin
        scan_row_r <= scan_row_r + 3'd1;
      end
      if (cfg_we && (cfg_index == CFG_DARK_THRESHOLD)) begin
        thr_r <= cfg_data;
      end
      if (cfg_we && (cfg_index == CFG_DIM_TIME)) begin
        dim_time_r <= cfg_data[9:0];
      end
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (cmd.scan) begin
      col_r      <= frame_r[scan_row_r];
      row_addr_r <= scan_row_r;
    end
  end

  assign out_column_bits = col_r;
  assign out_row_address = row_addr_r;
  assign out_on_time     = dim_on_time_r;

endmodule
`default_nettype wire
